// ===== rtl/nnts_pkg.sv =====
package nnts_pkg;

  localparam int PIXEL_W     = 32;
  localparam int THUMB_IDX_W = 9;
  localparam int DIM_REG_W   = 13;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 1'b0,
    CFG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Selection status for the item being accepted
  typedef struct packed {
    logic emit;
    logic last;
  } sel_flags_t;

endpackage

// ===== rtl/nnts_cfg.sv =====
module nnts_cfg #(
  parameter int THUMB_MAX_DIM  = 512,
  parameter int SOURCE_MAX_DIM = 4096,
  localparam int DW   = $clog2(SOURCE_MAX_DIM + 1),
  localparam int MAXD = (SOURCE_MAX_DIM > THUMB_MAX_DIM) ? SOURCE_MAX_DIM : THUMB_MAX_DIM,
  localparam int MDW  = $clog2(MAXD + 1),
  localparam int AW   = $clog2((2 * THUMB_MAX_DIM + 3) * MAXD + 1),
  localparam int SW   = AW + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nnts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnts_pkg::DIM_REG_W-1:0]  cfg_data,
  output logic [DW-1:0]                   w_eff,
  output logic [DW-1:0]                   h_eff,
  output logic [MDW-1:0]                  dim_d,
  output logic signed [SW-1:0]            thr1_w,
  output logic signed [SW-1:0]            thr3_w,
  output logic signed [SW-1:0]            thr1_h,
  output logic signed [SW-1:0]            thr3_h
);
  import nnts_pkg::*;

  localparam int EW = (DW > DIM_REG_W) ? DW : DIM_REG_W;

  logic [DW-1:0]         w_eff_r, w_eff_nxt;
  logic [DW-1:0]         h_eff_r, h_eff_nxt;
  logic [MDW-1:0]        dim_d_r, dim_d_nxt;
  logic signed [SW-1:0]  thr1_w_r, thr1_w_nxt;
  logic signed [SW-1:0]  thr3_w_r, thr3_w_nxt;
  logic signed [SW-1:0]  thr1_h_r, thr1_h_nxt;
  logic signed [SW-1:0]  thr3_h_r, thr3_h_nxt;
  logic [DW-1:0]         data_eff;

  // zero reads as one, anything above the source limit is held at the limit
  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [EW:0] vx;
    vx = (EW + 1)'(v);
    if (v == '0) begin
      return DW'(1);
    end else if (vx > (EW + 1)'(SOURCE_MAX_DIM)) begin
      return DW'(SOURCE_MAX_DIM);
    end
    return DW'(vx);
  endfunction

  // 2*T*len - k*d, kept signed since short sides go negative
  function automatic logic signed [SW-1:0] thresh(input logic [DW-1:0] len,
                                                  input logic [MDW-1:0] d,
                                                  input logic three);
    logic [AW-1:0] lim;
    logic [AW-1:0] sub;
    lim = AW'(len) * AW'(2 * THUMB_MAX_DIM);
    sub = three ? ((AW'(d) << 1) + AW'(d)) : AW'(d);
    return $signed({1'b0, lim}) - $signed({1'b0, sub});
  endfunction

  assign data_eff = clamp_dim(cfg_data);

  always_comb begin
    w_eff_nxt = w_eff_r;
    h_eff_nxt = h_eff_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_WIDTH:  w_eff_nxt = data_eff;
        CFG_SOURCE_HEIGHT: h_eff_nxt = data_eff;
        default:           w_eff_nxt = w_eff_r;
      endcase
    end
    if (!rst_n) begin
      w_eff_nxt = DW'(1);
      h_eff_nxt = DW'(1);
    end
  end

  always_comb begin
    logic [MDW-1:0] m;
    m = (w_eff_nxt > h_eff_nxt) ? MDW'(w_eff_nxt) : MDW'(h_eff_nxt);
    dim_d_nxt  = (m > MDW'(THUMB_MAX_DIM)) ? m : MDW'(THUMB_MAX_DIM);
    thr1_w_nxt = thresh(w_eff_nxt, dim_d_nxt, 1'b0);
    thr3_w_nxt = thresh(w_eff_nxt, dim_d_nxt, 1'b1);
    thr1_h_nxt = thresh(h_eff_nxt, dim_d_nxt, 1'b0);
    thr3_h_nxt = thresh(h_eff_nxt, dim_d_nxt, 1'b1);
  end

  always_ff @(posedge clk) begin
    w_eff_r  <= w_eff_nxt;
    h_eff_r  <= h_eff_nxt;
    dim_d_r  <= dim_d_nxt;
    thr1_w_r <= thr1_w_nxt;
    thr3_w_r <= thr3_w_nxt;
    thr1_h_r <= thr1_h_nxt;
    thr3_h_r <= thr3_h_nxt;
  end

  assign w_eff  = w_eff_r;
  assign h_eff  = h_eff_r;
  assign dim_d  = dim_d_r;
  assign thr1_w = thr1_w_r;
  assign thr3_w = thr3_w_r;
  assign thr1_h = thr1_h_r;
  assign thr3_h = thr3_h_r;

endmodule

// ===== rtl/nnts_sel.sv =====
module nnts_sel #(
  parameter int THUMB_MAX_DIM  = 512,
  parameter int SOURCE_MAX_DIM = 4096,
  localparam int DW   = $clog2(SOURCE_MAX_DIM + 1),
  localparam int MAXD = (SOURCE_MAX_DIM > THUMB_MAX_DIM) ? SOURCE_MAX_DIM : THUMB_MAX_DIM,
  localparam int MDW  = $clog2(MAXD + 1),
  localparam int AW   = $clog2((2 * THUMB_MAX_DIM + 3) * MAXD + 1),
  localparam int SW   = AW + 1,
  localparam int CW   = $clog2(THUMB_MAX_DIM + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  restart,
  input  logic                  accept,
  input  logic [DW-1:0]         w_eff,
  input  logic [DW-1:0]         h_eff,
  input  logic [MDW-1:0]        dim_d,
  input  logic signed [SW-1:0]  thr1_w,
  input  logic signed [SW-1:0]  thr3_w,
  input  logic signed [SW-1:0]  thr1_h,
  input  logic signed [SW-1:0]  thr3_h,
  output nnts_pkg::sel_flags_t  flags,
  output logic [CW-1:0]         out_col,
  output logic [CW-1:0]         out_row
);
  import nnts_pkg::*;

  localparam logic [AW-1:0] T_A = AW'(THUMB_MAX_DIM);

  logic [DW-1:0] scol_r, scol_nxt;
  logic [AW-1:0] scol_pos_r, scol_pos_nxt;
  logic [CW-1:0] ocol_r, ocol_nxt;
  logic [AW-1:0] ctgt_r, ctgt_nxt;
  logic [DW-1:0] srow_r, srow_nxt;
  logic [AW-1:0] srow_pos_r, srow_pos_nxt;
  logic [CW-1:0] orow_r, orow_nxt;
  logic [AW-1:0] rtgt_r, rtgt_nxt;
  logic          row_sel_r, row_sel_nxt;

  logic [AW-1:0] d_a;
  logic [AW-1:0] c2, r2;
  logic          col_hit, last_col, last_row, row_end, frame_end;
  logic [CW-1:0] orow_inc;
  logic [AW-1:0] rtgt_inc, srow_pos_inc, r2_inc;
  logic          row_sel_calc;

  assign d_a = AW'(dim_d);
  assign c2  = ctgt_r << 1;
  assign r2  = rtgt_r << 1;

  // column x exists while (2x+1)*d <= 2*T*w, and column zero always exists
  assign col_hit = ((ocol_r == '0) || ($signed({1'b0, c2}) <= thr1_w)) &&
                   (scol_pos_r <= ctgt_r) && (ctgt_r < scol_pos_r + T_A);
  assign last_col = $signed({1'b0, c2}) > thr3_w;
  assign last_row = $signed({1'b0, r2}) > thr3_h;

  assign row_end   = ({1'b0, scol_r} + (DW + 1)'(1)) >= {1'b0, w_eff};
  assign frame_end = row_end && (({1'b0, srow_r} + (DW + 1)'(1)) >= {1'b0, h_eff});

  // state of the next source row once this one closes
  assign orow_inc     = orow_r + CW'(row_sel_r);
  assign rtgt_inc     = row_sel_r ? (rtgt_r + d_a) : rtgt_r;
  assign srow_pos_inc = srow_pos_r + T_A;
  assign r2_inc       = rtgt_inc << 1;
  assign row_sel_calc = ((orow_inc == '0) || ($signed({1'b0, r2_inc}) <= thr1_h)) &&
                        (srow_pos_inc <= rtgt_inc) && (rtgt_inc < srow_pos_inc + T_A);

  assign flags.emit = row_sel_r && col_hit;
  assign flags.last = last_col && last_row;
  assign out_col    = ocol_r;
  assign out_row    = orow_r;

  always_comb begin
    scol_nxt     = scol_r;
    scol_pos_nxt = scol_pos_r;
    ocol_nxt     = ocol_r;
    ctgt_nxt     = ctgt_r;
    srow_nxt     = srow_r;
    srow_pos_nxt = srow_pos_r;
    orow_nxt     = orow_r;
    rtgt_nxt     = rtgt_r;
    row_sel_nxt  = row_sel_r;
    if (!rst_n || restart || (accept && frame_end)) begin
      scol_nxt     = '0;
      scol_pos_nxt = '0;
      ocol_nxt     = '0;
      ctgt_nxt     = '0;
      srow_nxt     = '0;
      srow_pos_nxt = '0;
      orow_nxt     = '0;
      rtgt_nxt     = '0;
      row_sel_nxt  = 1'b1;
    end else if (accept) begin
      if (row_end) begin
        scol_nxt     = '0;
        scol_pos_nxt = '0;
        ocol_nxt     = '0;
        ctgt_nxt     = '0;
        srow_nxt     = srow_r + DW'(1);
        srow_pos_nxt = srow_pos_inc;
        orow_nxt     = orow_inc;
        rtgt_nxt     = rtgt_inc;
        row_sel_nxt  = row_sel_calc;
      end else begin
        scol_nxt     = scol_r + DW'(1);
        scol_pos_nxt = scol_pos_r + T_A;
        if (col_hit) begin
          ocol_nxt = ocol_r + CW'(1);
          ctgt_nxt = ctgt_r + d_a;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    scol_r     <= scol_nxt;
    scol_pos_r <= scol_pos_nxt;
    ocol_r     <= ocol_nxt;
    ctgt_r     <= ctgt_nxt;
    srow_r     <= srow_nxt;
    srow_pos_r <= srow_pos_nxt;
    orow_r     <= orow_nxt;
    rtgt_r     <= rtgt_nxt;
    row_sel_r  <= row_sel_nxt;
  end

endmodule

// ===== rtl/nnts_oreg.sv =====
module nnts_oreg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [nnts_pkg::PIXEL_W-1:0]      pixel,
  input  logic [nnts_pkg::THUMB_IDX_W-1:0]  col,
  input  logic [nnts_pkg::THUMB_IDX_W-1:0]  row,
  input  logic                              last,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [nnts_pkg::PIXEL_W-1:0]      out_pixel_out,
  output logic [nnts_pkg::THUMB_IDX_W-1:0]  out_thumb_col,
  output logic [nnts_pkg::THUMB_IDX_W-1:0]  out_thumb_row,
  output logic                              out_last_of_thumbnail
);
  import nnts_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [PIXEL_W-1:0]     pixel_r;
  logic [THUMB_IDX_W-1:0] col_r;
  logic [THUMB_IDX_W-1:0] row_r;
  logic                   last_r;

  // hold while stalled, refill on load
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r <= pixel;
      col_r   <= col;
      row_r   <= row;
      last_r  <= last;
    end
  end

  assign out_valid             = valid_r;
  assign out_pixel_out         = pixel_r;
  assign out_thumb_col         = col_r;
  assign out_thumb_row         = row_r;
  assign out_last_of_thumbnail = last_r;

endmodule

// ===== rtl/nearest_neighbor_thumbnail_scaler.sv =====
// A selected pixel appears on the result port in the cycle after it is accepted.
// Throughput: one item per cycle; the single result register sets this and the input
// stalls only while that register holds an item that is itself stalled.
// Reset (synchronous, rst_n low): source geometry returns to 1 x 1, the frame position
// clears and the result register empties. A configuration write also restarts the frame.
module nearest_neighbor_thumbnail_scaler #(
  parameter int THUMB_MAX_DIM  = 512,
  parameter int SOURCE_MAX_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nnts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnts_pkg::DIM_REG_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nnts_pkg::PIXEL_W-1:0]      in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nnts_pkg::PIXEL_W-1:0]      out_pixel_out,
  output logic [nnts_pkg::THUMB_IDX_W-1:0]  out_thumb_col,
  output logic [nnts_pkg::THUMB_IDX_W-1:0]  out_thumb_row,
  output logic                              out_last_of_thumbnail
);
  import nnts_pkg::*;

  localparam int DW   = $clog2(SOURCE_MAX_DIM + 1);
  localparam int MAXD = (SOURCE_MAX_DIM > THUMB_MAX_DIM) ? SOURCE_MAX_DIM : THUMB_MAX_DIM;
  localparam int MDW  = $clog2(MAXD + 1);
  localparam int AW   = $clog2((2 * THUMB_MAX_DIM + 3) * MAXD + 1);
  localparam int SW   = AW + 1;
  localparam int CW   = $clog2(THUMB_MAX_DIM + 1);
  // wide enough both for the counters and for the 9-bit result fields
  localparam int XW   = (CW > THUMB_IDX_W) ? CW : THUMB_IDX_W;

  logic [DW-1:0]        w_eff, h_eff;
  logic [MDW-1:0]       dim_d;
  logic signed [SW-1:0] thr1_w, thr3_w, thr1_h, thr3_h;
  sel_flags_t           flags;
  logic [CW-1:0]        sel_col, sel_row;
  logic [XW-1:0]        col_x, row_x;
  logic                 accept;

  // Geometry: effective width and height, the scale divisor d = max(w, h, T) and
  // the thresholds that tell whether a thumbnail column or row exists and whether it is the last.
  nnts_cfg #(
    .THUMB_MAX_DIM  (THUMB_MAX_DIM),
    .SOURCE_MAX_DIM (SOURCE_MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .dim_d     (dim_d),
    .thr1_w    (thr1_w),
    .thr3_w    (thr3_w),
    .thr1_h    (thr1_h),
    .thr3_h    (thr3_h)
  );

  // Accept whenever the result register is free or draining this cycle; an item
  // that is dropped needs no space at all but is held back for simplicity of timing.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Raster position and accumulators: each thumbnail column keeps x*d, compared
  // with the source column times T, so no division is needed anywhere.
  nnts_sel #(
    .THUMB_MAX_DIM  (THUMB_MAX_DIM),
    .SOURCE_MAX_DIM (SOURCE_MAX_DIM)
  ) u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .accept  (accept),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .dim_d   (dim_d),
    .thr1_w  (thr1_w),
    .thr3_w  (thr3_w),
    .thr1_h  (thr1_h),
    .thr3_h  (thr3_h),
    .flags   (flags),
    .out_col (sel_col),
    .out_row (sel_row)
  );

  // Thumbnail indices leave on 9 bits; keep the low bits only.
  assign col_x = XW'(sel_col);
  assign row_x = XW'(sel_row);

  nnts_oreg u_oreg (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .load                  (accept && flags.emit),
    .pixel                 (in_pixel_in),
    .col                   (col_x[THUMB_IDX_W-1:0]),
    .row                   (row_x[THUMB_IDX_W-1:0]),
    .last                  (flags.last),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_pixel_out         (out_pixel_out),
    .out_thumb_col         (out_thumb_col),
    .out_thumb_row         (out_thumb_row),
    .out_last_of_thumbnail (out_last_of_thumbnail)
  );

endmodule

// ===== rtl/nnts_chk.sv =====
module nnts_chk #(
  parameter int THUMB_MAX_DIM = 512
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [nnts_pkg::PIXEL_W-1:0]      out_pixel_out,
  input logic [nnts_pkg::THUMB_IDX_W-1:0]  out_thumb_col,
  input logic [nnts_pkg::THUMB_IDX_W-1:0]  out_thumb_row,
  input logic                              out_last_of_thumbnail
);
  import nnts_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) &&
      $stable(out_thumb_col) && $stable(out_thumb_row) && $stable(out_last_of_thumbnail))
    else $error("stalled result changed");

  // input is held back only by a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without back-pressure");

  // indices stay inside the thumbnail when they fit the port
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (THUMB_MAX_DIM > 512) ||
      ((out_thumb_col < THUMB_MAX_DIM) && (out_thumb_row < THUMB_MAX_DIM)))
    else $error("thumbnail index out of range");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_neighbor_thumbnail_scaler nnts_chk #(
  .THUMB_MAX_DIM (THUMB_MAX_DIM)
) u_nnts_chk (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_pixel_out         (out_pixel_out),
  .out_thumb_col         (out_thumb_col),
  .out_thumb_row         (out_thumb_row),
  .out_last_of_thumbnail (out_last_of_thumbnail)
);
